>>> rtl/core/tbpc_pkg.sv
// Shared constants for the two-button press classifier.
`default_nettype none

package tbpc_pkg;

    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int EVENT_W     = 3;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 8'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1200;

    localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT_A   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_LONG_A    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SHORT_B   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_LONG_B    = 3'd4;
    localparam logic [EVENT_W-1:0] EV_BOTH_LONG = 3'd5;

endpackage

`default_nettype wire

>>> rtl/core/two_button_press_classifier.sv
// Two-button debounce and short/long/chord press classifier, top level.
// An accepted input passes through the input register, then the result register, before result valid.
// Throughput: one item per cycle while m_tready holds; all per-item work is one pass of compares and subtracts.
// The input register frees itself whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous): both registers empty, button and chord state cleared,
// debounce_time = 30 and long_press_time = 1200.
`default_nettype none

module two_button_press_classifier
    import tbpc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,    // [0] raw_a, [1] raw_b, [33:2] now_time
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,    // [2:0] event_code
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    logic               in_valid_reg;
    logic               raw_a_in_reg;
    logic               raw_b_in_reg;
    logic [TIME_W-1:0]  now_in_reg;
    logic               out_valid_reg;
    logic [EVENT_W-1:0] event_reg;

    logic [CFG_W-1:0]   debounce_reg;
    logic [CFG_W-1:0]   long_press_reg;

    logic               raw_a_reg, stable_a_reg, raw_b_reg, stable_b_reg;
    logic [TIME_W-1:0]  change_a_reg, press_a_reg, change_b_reg, press_b_reg;
    logic               chord_on_reg, chord_reported_reg;
    logic [TIME_W-1:0]  chord_start_reg;
    logic               skip_a_reg, skip_b_reg;

    logic               raw_a_next, stable_a_next, raw_b_next, stable_b_next;
    logic [TIME_W-1:0]  change_a_next, press_a_next, change_b_next, press_b_next;
    logic               chord_on_next, chord_reported_next;
    logic [TIME_W-1:0]  chord_start_next;
    logic               skip_a_next, skip_b_next;
    logic [EVENT_W-1:0] event_next;

    logic               advance;
    logic               a_settled, b_settled;
    logic [TIME_W-1:0]  chord_age;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_TDATA_W-EVENT_W){1'b0}}, event_reg};
    assign cfg_ready = 1'b1;

    always_comb begin
        // debounce A
        raw_a_next    = raw_a_in_reg;
        change_a_next = (raw_a_in_reg != raw_a_reg) ? now_in_reg : change_a_reg;
        a_settled     = (stable_a_reg != raw_a_next) &&
                        ((now_in_reg - change_a_next) >= {16'd0, debounce_reg});
        stable_a_next = a_settled ? raw_a_next : stable_a_reg;
        press_a_next  = (a_settled && raw_a_next) ? now_in_reg : press_a_reg;

        // debounce B
        raw_b_next    = raw_b_in_reg;
        change_b_next = (raw_b_in_reg != raw_b_reg) ? now_in_reg : change_b_reg;
        b_settled     = (stable_b_reg != raw_b_next) &&
                        ((now_in_reg - change_b_next) >= {16'd0, debounce_reg});
        stable_b_next = b_settled ? raw_b_next : stable_b_reg;
        press_b_next  = (b_settled && raw_b_next) ? now_in_reg : press_b_reg;

        chord_on_next       = chord_on_reg;
        chord_reported_next = chord_reported_reg;
        chord_start_next    = chord_start_reg;
        skip_a_next         = skip_a_reg;
        skip_b_next         = skip_b_reg;
        event_next          = EV_NONE;
        chord_age           = now_in_reg - chord_start_reg;

        if (stable_a_next && stable_b_next) begin
            if (!chord_on_reg) begin
                chord_on_next       = 1'b1;
                chord_reported_next = 1'b0;
                chord_start_next    = now_in_reg;
                skip_a_next         = 1'b1;
                skip_b_next         = 1'b1;
                chord_age           = '0;
            end
            if ((!chord_reported_reg || !chord_on_reg) &&
                (chord_age >= {16'd0, long_press_reg})) begin
                chord_reported_next = 1'b1;
                event_next          = EV_BOTH_LONG;
            end
        end else begin
            if (chord_on_reg && !stable_a_next && !stable_b_next) begin
                chord_on_next = 1'b0;
            end
            if (a_settled && !stable_a_next && !skip_a_reg) begin
                event_next = ((now_in_reg - press_a_reg) >= {16'd0, long_press_reg}) ?
                             EV_LONG_A : EV_SHORT_A;
            end else begin
                if (a_settled && !stable_a_next) begin
                    skip_a_next = 1'b0;
                end
                if (b_settled && !stable_b_next) begin
                    if (skip_b_reg) begin
                        skip_b_next = 1'b0;
                    end else begin
                        event_next = ((now_in_reg - press_b_reg) >=
                                      {16'd0, long_press_reg}) ? EV_LONG_B : EV_SHORT_B;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            debounce_reg       <= DEBOUNCE_RESET;
            long_press_reg     <= LONG_PRESS_RESET;
            raw_a_reg          <= 1'b0;
            stable_a_reg       <= 1'b0;
            change_a_reg       <= '0;
            press_a_reg        <= '0;
            raw_b_reg          <= 1'b0;
            stable_b_reg       <= 1'b0;
            change_b_reg       <= '0;
            press_b_reg        <= '0;
            chord_on_reg       <= 1'b0;
            chord_reported_reg <= 1'b0;
            chord_start_reg    <= '0;
            skip_a_reg         <= 1'b0;
            skip_b_reg         <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                raw_a_in_reg <= s_tdata[0];
                raw_b_in_reg <= s_tdata[1];
                now_in_reg   <= s_tdata[TIME_W+1:2];
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg      <= 1'b1;
                event_reg          <= event_next;
                raw_a_reg          <= raw_a_next;
                stable_a_reg       <= stable_a_next;
                change_a_reg       <= change_a_next;
                press_a_reg        <= press_a_next;
                raw_b_reg          <= raw_b_next;
                stable_b_reg       <= stable_b_next;
                change_b_reg       <= change_b_next;
                press_b_reg        <= press_b_next;
                chord_on_reg       <= chord_on_next;
                chord_reported_reg <= chord_reported_next;
                chord_start_reg    <= chord_start_next;
                skip_a_reg         <= skip_a_next;
                skip_b_reg         <= skip_b_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                    REG_LONG_PRESS: long_press_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (event_reg <= EV_BOTH_LONG))
        else $error("event code out of range");

    a_both_long_chord: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && event_next == EV_BOTH_LONG) |=>
            (stable_a_reg && stable_b_reg && chord_on_reg && chord_reported_reg))
        else $error("both-long event without an active reported chord");

    a_release_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (event_next == EV_SHORT_A || event_next == EV_LONG_A)) |=>
            (!stable_a_reg && $past(stable_a_reg)))
        else $error("A event without a stable release of A");

    a_release_b: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (event_next == EV_SHORT_B || event_next == EV_LONG_B)) |=>
            (!stable_b_reg && $past(stable_b_reg)))
        else $error("B event without a stable release of B");

endmodule

`default_nettype wire
